[rtl/dcst_pkg.sv]
// Shared codes, widths and types of the delayed call slot table.
package dcst_pkg;

   localparam int unsigned HANDLER_BITS = 16;
   localparam int unsigned PARAM_BITS   = 32;
   localparam int unsigned TICK_IN_BITS = 32;
   localparam int unsigned PROC_BITS    = 8;

   localparam int unsigned MAX_RESULTS   = 16;
   localparam int unsigned FIRE_CNT_BITS = 5;

   localparam int unsigned REQ_DATA_BITS = 128;
   localparam int unsigned RSP_DATA_BITS = 56;

   localparam logic [2:0] OP_ADD        = 3'd0;
   localparam logic [2:0] OP_REMOVE     = 3'd1;
   localparam logic [2:0] OP_REMOVE_ALL = 3'd2;
   localparam logic [2:0] OP_QUERY      = 3'd3;
   localparam logic [2:0] OP_SWEEP      = 3'd4;

   localparam logic [2:0] KIND_ADD     = 3'd0;
   localparam logic [2:0] KIND_REMOVED = 3'd1;
   localparam logic [2:0] KIND_QUERY   = 3'd2;
   localparam logic [2:0] KIND_FIRED   = 3'd3;
   localparam logic [2:0] KIND_NONE    = 3'd4;

   localparam logic [1:0] POL_CLEAR  = 2'd0;
   localparam logic [1:0] POL_CANCEL = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

endpackage

[rtl/delayed_call_slot_table.sv]
// Top level of the delayed call slot table: slot storage, scan sequencer and result register.
//
// A table of SLOTS one-shot delayed calls. Add, remove, query and sweep each take one
// transaction; the sequencer accepts it, walks the slot memory slot by slot through its
// single registered read port and shared match/expiry compare, and then posts the result.
// Remove-all skips the walk. A sweep emits one transaction per fired slot (at most 16, in
// slot order), or one none result if no slot fires, and stalls its scan while a further
// fired slot meets a full result register, so a slow result side stretches it. Unknown
// opcodes are accepted and dropped. The request side is ready only while the sequencer is idle.
module delayed_call_slot_table
   import dcst_pkg::*;
#(
   parameter int unsigned SLOTS     = 16,
   parameter int unsigned TICK_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // handler_id[15:0], param_tag[47:16], param_compare[48], dup_policy[50:49],
   // delay_ticks[82:51], owner_process[90:83], now_tick[122:91], zero fill above
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // opcode[2:0]
   input  logic [2:0]               req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // ok[0], fired_handler[16:1], fired_param[48:17], zero fill above
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // result_kind[2:0]
   output logic [2:0]               rsp_tuser,
   output logic                     rsp_tlast,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_data
);

   localparam int unsigned IW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned SW       = (TICK_BITS < TICK_IN_BITS) ? TICK_BITS : TICK_IN_BITS;
   localparam bit          WRAP_FAR = (TICK_BITS > TICK_IN_BITS);

   logic [HANDLER_BITS-1:0] mem_handler [SLOTS];
   logic [PARAM_BITS-1:0]   mem_param   [SLOTS];
   logic [SW-1:0]           mem_start   [SLOTS];
   logic [TICK_IN_BITS-1:0] mem_delay   [SLOTS];
   logic [PROC_BITS-1:0]    mem_process [SLOTS];

   logic [HANDLER_BITS-1:0] rd_handler_ff;
   logic [PARAM_BITS-1:0]   rd_param_ff;
   logic [SW-1:0]           rd_start_ff;
   logic [TICK_IN_BITS-1:0] rd_delay_ff;
   logic [PROC_BITS-1:0]    rd_process_ff;
   logic [IW-1:0]           rd_addr;
   logic                    wr_en;
   logic [IW-1:0]           wr_addr;

   state_type               state_ff, state_in;
   logic [IW-1:0]           idx_ff, idx_in;
   logic [2:0]              op_ff, op_in;
   logic [HANDLER_BITS-1:0] h_ff, h_in;
   logic [PARAM_BITS-1:0]   tag_ff, tag_in;
   logic                    cmp_ff, cmp_in;
   logic [1:0]              pol_ff, pol_in;
   logic [TICK_IN_BITS-1:0] dly_ff, dly_in;
   logic [PROC_BITS-1:0]    proc_ff, proc_in;
   logic [SW-1:0]           now_ff, now_in;
   logic                    pme_ff, pme_in;
   logic [SLOTS-1:0]        valid_ff, valid_in;
   logic [SLOTS-1:0]        match_ff, match_in;
   logic                    dup_ff, dup_in;
   logic                    free_found_ff, free_found_in;
   logic [IW-1:0]           free_idx_ff, free_idx_in;
   logic                    cand_found_ff, cand_found_in;
   logic [IW-1:0]           cand_idx_ff, cand_idx_in;
   logic                    pend_ff, pend_in;
   logic [HANDLER_BITS-1:0] pend_h_ff, pend_h_in;
   logic [PARAM_BITS-1:0]   pend_p_ff, pend_p_in;
   logic [FIRE_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [2:0]              rsp_kind_ff, rsp_kind_in;
   logic                    rsp_ok_ff, rsp_ok_in;
   logic [HANDLER_BITS-1:0] rsp_h_ff, rsp_h_in;
   logic [PARAM_BITS-1:0]   rsp_p_ff, rsp_p_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    out_busy;
   logic                    hit;
   logic                    fire;
   logic                    step;
   logic                    last_idx;
   logic [SW:0]             diff;
   logic [TICK_IN_BITS-1:0] elapsed;
   logic                    expired;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS - PARAM_BITS - HANDLER_BITS - 1){1'b0}},
                        rsp_p_ff, rsp_h_ff, rsp_ok_ff};

   assign out_busy = rsp_valid_ff && !rsp_tready;
   assign last_idx = (idx_ff == IW'(SLOTS - 1));

   // shared match and expiry unit on the slot under the scan index
   assign hit = valid_ff[idx_ff] && (rd_handler_ff == h_ff) &&
                (!cmp_ff || (tag_ff == '0) || (rd_param_ff == tag_ff));
   assign diff    = {1'b0, now_ff} - {1'b0, rd_start_ff};
   assign elapsed = TICK_IN_BITS'(diff[SW-1:0]);
   assign expired = (rd_delay_ff == '0) || (WRAP_FAR && diff[SW]) || (elapsed >= rd_delay_ff);
   assign fire    = (op_ff == OP_SWEEP) && valid_ff[idx_ff] &&
                    (!pme_ff || (rd_process_ff == proc_ff)) && expired;
   assign step    = !(fire && pend_ff && out_busy);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      op_in         = op_ff;
      h_in          = h_ff;
      tag_in        = tag_ff;
      cmp_in        = cmp_ff;
      pol_in        = pol_ff;
      dly_in        = dly_ff;
      proc_in       = proc_ff;
      now_in        = now_ff;
      pme_in        = pme_ff;
      valid_in      = valid_ff;
      match_in      = match_ff;
      dup_in        = dup_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      cand_found_in = cand_found_ff;
      cand_idx_in   = cand_idx_ff;
      pend_in       = pend_ff;
      pend_h_in     = pend_h_ff;
      pend_p_in     = pend_p_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_h_in      = rsp_h_ff;
      rsp_p_in      = rsp_p_ff;
      rsp_last_in   = rsp_last_ff;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = free_idx_ff;

      if (csr_valid && csr_ready) begin
         pme_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in         = req_tuser;
               h_in          = req_tdata[15:0];
               tag_in        = req_tdata[47:16];
               cmp_in        = req_tdata[48];
               pol_in        = req_tdata[50:49];
               dly_in        = req_tdata[82:51];
               proc_in       = req_tdata[90:83];
               now_in        = req_tdata[91 +: SW];
               idx_in        = '0;
               match_in      = '0;
               dup_in        = 1'b0;
               free_found_in = 1'b0;
               cand_found_in = 1'b0;
               pend_in       = 1'b0;
               cnt_in        = '0;
               if ((req_tuser == OP_ADD) || (req_tuser == OP_REMOVE) ||
                   (req_tuser == OP_QUERY) || (req_tuser == OP_SWEEP)) begin
                  state_in = ST_SCAN;
               end else if (req_tuser == OP_REMOVE_ALL) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            rd_addr = idx_ff;
            if (step) begin
               if (hit) begin
                  match_in[idx_ff] = 1'b1;
                  dup_in           = 1'b1;
               end
               if (!valid_ff[idx_ff] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = idx_ff;
               end
               if ((!valid_ff[idx_ff] || hit) && !cand_found_ff) begin
                  cand_found_in = 1'b1;
                  cand_idx_in   = idx_ff;
               end
               if (fire) begin
                  if (pend_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_FIRED;
                     rsp_ok_in    = 1'b0;
                     rsp_h_in     = pend_h_ff;
                     rsp_p_in     = pend_p_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_in          = 1'b1;
                  pend_h_in        = rd_handler_ff;
                  pend_p_in        = rd_param_ff;
                  valid_in[idx_ff] = 1'b0;
                  cnt_in           = cnt_ff + 1'b1;
               end
               if (last_idx || (fire && (cnt_ff == FIRE_CNT_BITS'(MAX_RESULTS - 1)))) begin
                  state_in = ST_DONE;
                  rd_addr  = '0;
               end else begin
                  idx_in  = idx_ff + 1'b1;
                  rd_addr = idx_ff + 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (!out_busy) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b0;
               rsp_h_in     = '0;
               rsp_p_in     = '0;
               rsp_last_in  = 1'b1;
               case (op_ff)
                  OP_ADD: begin
                     rsp_kind_in = KIND_ADD;
                     if (h_ff == '0) begin
                        rsp_ok_in = 1'b0;
                     end else if (dup_ff && (pol_ff == POL_CANCEL)) begin
                        rsp_ok_in = 1'b1;
                     end else if (dup_ff && (pol_ff == POL_CLEAR)) begin
                        valid_in              = valid_ff & ~match_ff;
                        valid_in[cand_idx_ff] = 1'b1;
                        wr_en                 = 1'b1;
                        wr_addr               = cand_idx_ff;
                        rsp_ok_in             = 1'b1;
                     end else if (free_found_ff) begin
                        valid_in[free_idx_ff] = 1'b1;
                        wr_en                 = 1'b1;
                        rsp_ok_in             = 1'b1;
                     end
                  end
                  OP_REMOVE: begin
                     rsp_kind_in = KIND_REMOVED;
                     valid_in    = valid_ff & ~match_ff;
                  end
                  OP_REMOVE_ALL: begin
                     rsp_kind_in = KIND_REMOVED;
                     valid_in    = '0;
                  end
                  OP_QUERY: begin
                     rsp_kind_in = KIND_QUERY;
                     rsp_ok_in   = dup_ff;
                  end
                  OP_SWEEP: begin
                     if (pend_ff) begin
                        rsp_kind_in = KIND_FIRED;
                        rsp_h_in    = pend_h_ff;
                        rsp_p_in    = pend_p_ff;
                     end else begin
                        rsp_kind_in = KIND_NONE;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_handler[wr_addr] <= h_ff;
         mem_param[wr_addr]   <= tag_ff;
         mem_start[wr_addr]   <= now_ff;
         mem_delay[wr_addr]   <= dly_ff;
         mem_process[wr_addr] <= proc_ff;
      end
      rd_handler_ff <= mem_handler[rd_addr];
      rd_param_ff   <= mem_param[rd_addr];
      rd_start_ff   <= mem_start[rd_addr];
      rd_delay_ff   <= mem_delay[rd_addr];
      rd_process_ff <= mem_process[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         pme_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         pme_ff       <= pme_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      op_ff         <= op_in;
      h_ff          <= h_in;
      tag_ff        <= tag_in;
      cmp_ff        <= cmp_in;
      pol_ff        <= pol_in;
      dly_ff        <= dly_in;
      proc_ff       <= proc_in;
      now_ff        <= now_in;
      match_ff      <= match_in;
      dup_ff        <= dup_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      cand_found_ff <= cand_found_in;
      cand_idx_ff   <= cand_idx_in;
      pend_h_ff     <= pend_h_in;
      pend_p_ff     <= pend_p_in;
      cnt_ff        <= cnt_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_h_ff      <= rsp_h_in;
      rsp_p_ff      <= rsp_p_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

[rtl/dcst_checker.sv]
// Port-level checks of the delayed call slot table and their bind.
module dcst_checker
   import dcst_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic [2:0]               req_tuser,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic [2:0]               rsp_tuser,
   input logic                     rsp_tlast
);

   rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result transaction changed");

   busy_during_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken before sweep burst finished");

   single_results_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != KIND_FIRED) |-> rsp_tlast && (rsp_tdata[16:1] == '0))
      else $error("non-fired result not final or carries a handler");

   sweep_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_SWEEP) |=> !req_tready)
      else $error("ready right after sweep transaction");

endmodule

bind delayed_call_slot_table dcst_checker u_dcst_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
